// ----- rtl/wto_pkg.sv -----
// ----------------------------------------------------------------------------
// wto_pkg: shared types and constants of the wavetable oscillator
// Table geometry, item codes, fixed-point constants and the sequencer states.
// ----------------------------------------------------------------------------
package wto_pkg;

  // Table geometry and word widths
  localparam int TABLE_SIZE  = 1024;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int PHASE_W     = IDX_W + FRAC_BITS;
  localparam int MEM_DEPTH   = 3 * TABLE_SIZE;
  localparam int MEM_AW      = IDX_W + 2;

  // Mixer level and weights, 14 fractional bits
  localparam int LVL_W = 15;
  localparam logic [LVL_W-1:0] ONE_Q14 = 15'd16384;

  // Reciprocal of 5: floor(x * RECIP_DIV5 / 2^RECIP_SHIFT) == floor(x / 5)
  // for every x below 2^18
  localparam int RECIP_SHIFT = 20;
  localparam logic [17:0] RECIP_DIV5 = 18'd209716;

  // Item codes carried in tuser
  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_SAMPLE  = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TBL_SQUARE   = 2'd0,
    TBL_SINE     = 2'd1,
    TBL_TRIANGLE = 2'd2,
    TBL_NONE     = 2'd3
  } tbl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX,
    S_RD_SQ,
    S_RD_SI,
    S_RD_TR,
    S_DRAIN_A,
    S_DRAIN_B,
    S_DRAIN_C,
    S_DONE
  } state_t;

endpackage

// ----- rtl/wavetable_oscillator.sv -----
// ----------------------------------------------------------------------------
// wavetable_oscillator: three-table crossfading wavetable oscillator
// Square, sine and triangle tables share one synchronous RAM; a small
// sequencer reads the three entries at the phase and runs them through a
// blend / weight / divide-by-constant pipeline into a saturated sum.
//
// Usage: items arrive on in_*; in_tuser selects the kind. A load transaction
// writes one table word in its accept cycle and the block is ready again in
// the next cycle. A refresh transaction updates the mixer level in the cycle
// after accept, in state S_MIX, while no transaction is taken. A sample
// transaction runs three RAM reads on the single read port, then a four-stage
// term pipeline that drains before the sum is saturated; the next transaction
// is taken once the saturated sum has entered the output register. Only
// sample transactions produce a result on out_*. The output register holds a
// result until taken; new loads and refreshes are taken meanwhile, and a later
// sample waits in its final step until the output register is free. cfg_*
// writes the phase increment, taken in any cycle. Reset clears phase, mixer
// level, previous values and increment; table contents are undefined until
// written.
// ----------------------------------------------------------------------------
module wavetable_oscillator
  import wto_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input: func [1:0], table_select [3:2]
  input  logic [3:0]  in_tuser,
  // input: table_index [9:0], table_word [25:10], shape_value [40:26], zero pad
  input  logic [47:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // output: sample [15:0]
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // phase_increment [25:0]
  input  logic [25:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  // Field decode
  func_t                    in_func;
  tbl_t                     in_sel;
  logic [IDX_W-1:0]         in_idx;
  logic [SAMPLE_BITS-1:0]   in_word;
  logic [LVL_W-1:0]         in_shape;

  assign in_func  = func_t'(in_tuser[1:0]);
  assign in_sel   = tbl_t'(in_tuser[3:2]);
  assign in_idx   = in_tdata[9:0];
  assign in_word  = in_tdata[25:10];
  assign in_shape = in_tdata[40:26];

  // State
  state_t                    state_r, state_nxt;
  logic [PHASE_W-1:0]        inc_r;
  logic [PHASE_W-1:0]        phase_r;
  logic [IDX_W-1:0]          pos_r;
  logic [LVL_W-1:0]          mix_r;
  logic [17:0]               mix_num_r;
  logic [LVL_W-1:0]          wsq_r, wsi_r, wtr_r;
  logic signed [SAMPLE_BITS-1:0] last_sq_r, last_si_r, last_tr_r;

  // Sequencer outputs
  logic                      mem_we;
  logic                      mem_re;
  logic [MEM_AW-1:0]         rd_addr;
  logic                      s1_load;
  logic                      out_load;
  logic                      smp_acc;
  logic                      mix_acc;

  // Memory
  logic signed [SAMPLE_BITS-1:0] wave_mem [0:MEM_DEPTH-1];
  logic signed [SAMPLE_BITS-1:0] rdata_r;

  // Term pipeline
  logic                      s1_v_r, s2_v_r, s3_v_r;
  logic signed [19:0]        blend_r;
  logic [LVL_W-1:0]          w1_r;
  logic signed [35:0]        prod_r;
  logic [35:0]               qm_r;
  logic                      neg3_r;
  logic signed [17:0]        acc_r;

  // Output register
  logic                      out_valid_r;
  logic [SAMPLE_BITS-1:0]    out_data_r;

  // Configuration port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= '0;
    end else if (cfg_valid) begin
      inc_r <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_func)
            FUNC_REFRESH: state_nxt = S_MIX;
            FUNC_SAMPLE:  state_nxt = S_RD_SQ;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_MIX:     state_nxt = S_IDLE;
      S_RD_SQ:   state_nxt = S_RD_SI;
      S_RD_SI:   state_nxt = S_RD_TR;
      S_RD_TR:   state_nxt = S_DRAIN_A;
      S_DRAIN_A: state_nxt = S_DRAIN_B;
      S_DRAIN_B: state_nxt = S_DRAIN_C;
      S_DRAIN_C: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = {TBL_SQUARE, phase_r[PHASE_W-1 -: IDX_W]};
    s1_load   = 1'b0;
    out_load  = 1'b0;
    smp_acc   = 1'b0;
    mix_acc   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        mem_we    = in_tvalid && (in_func == FUNC_LOAD) && (in_sel != TBL_NONE);
        smp_acc   = in_tvalid && (in_func == FUNC_SAMPLE);
        mix_acc   = in_tvalid && (in_func == FUNC_REFRESH);
        mem_re    = smp_acc;
      end
      S_RD_SQ: begin
        mem_re  = 1'b1;
        rd_addr = {TBL_SINE, pos_r};
        s1_load = 1'b1;
      end
      S_RD_SI: begin
        mem_re  = 1'b1;
        rd_addr = {TBL_TRIANGLE, pos_r};
        s1_load = 1'b1;
      end
      S_RD_TR: begin
        s1_load = 1'b1;
      end
      S_DONE: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wave_mem[{in_sel, in_idx}] <= in_word;
    end
    if (mem_re) begin
      rdata_r <= wave_mem[rd_addr];
    end
  end

  // Crossfade weights from the mixer level
  logic [LVL_W-1:0] lvl_c, lvl_d;

  always_comb begin
    if (mix_r > ONE_Q14) begin
      lvl_c = ONE_Q14;
      lvl_d = mix_r - ONE_Q14;
    end else begin
      lvl_c = mix_r;
      lvl_d = '0;
    end
  end

  // Advance phase and latch weights on a sample transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (smp_acc) begin
      phase_r <= phase_r + inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      pos_r <= phase_r[PHASE_W-1 -: IDX_W];
      wsq_r <= ONE_Q14 - lvl_c;
      wsi_r <= lvl_c - lvl_d;
      wtr_r <= lvl_d;
    end
  end

  // Mixer smoothing: level = (4*level + shape + 2) / 5
  logic [35:0] mix_prod;

  assign mix_prod = mix_num_r * RECIP_DIV5;

  always_ff @(posedge clk) begin
    if (mix_acc) begin
      mix_num_r <= {1'b0, mix_r, 2'b00} + {3'b000, in_shape} + 18'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= '0;
    end else if (state_r == S_MIX) begin
      mix_r <= mix_prod[RECIP_SHIFT +: LVL_W];
    end
  end

  // Stage 1: blend 3*current + 7*previous, select weight, retire previous
  logic signed [SAMPLE_BITS-1:0] last_sel;
  logic [LVL_W-1:0]              w_sel;
  logic signed [19:0]            cur_x, last_x, blend_nxt;

  always_comb begin
    case (state_r)
      S_RD_SI: begin
        last_sel = last_si_r;
        w_sel    = wsi_r;
      end
      S_RD_TR: begin
        last_sel = last_tr_r;
        w_sel    = wtr_r;
      end
      default: begin
        last_sel = last_sq_r;
        w_sel    = wsq_r;
      end
    endcase
  end

  assign cur_x     = {{4{rdata_r[SAMPLE_BITS-1]}}, rdata_r};
  assign last_x    = {{4{last_sel[SAMPLE_BITS-1]}}, last_sel};
  assign blend_nxt = (cur_x <<< 1) + cur_x + (last_x <<< 3) - last_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sq_r <= '0;
      last_si_r <= '0;
      last_tr_r <= '0;
    end else if (s1_load) begin
      case (state_r)
        S_RD_SQ: last_sq_r <= rdata_r;
        S_RD_SI: last_si_r <= rdata_r;
        S_RD_TR: last_tr_r <= rdata_r;
        default: last_sq_r <= last_sq_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      blend_r <= blend_nxt;
      w1_r    <= w_sel;
    end
  end

  // Stage 2: weight times blend
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      prod_r <= $signed({1'b0, w1_r}) * blend_r;
    end
  end

  // Stage 3: magnitude, drop 2^15, divide by 5 via reciprocal
  logic [35:0] prod_mag;
  logic [17:0] prod_hi;

  assign prod_mag = prod_r[35] ? (36'd0 - prod_r) : prod_r;
  assign prod_hi  = prod_mag[32:15];

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      qm_r   <= prod_hi * RECIP_DIV5;
      neg3_r <= prod_r[35];
    end
  end

  // Stage 4: signed quotient into the accumulator
  logic signed [17:0] quot_x;

  assign quot_x = $signed({2'b00, qm_r[35:RECIP_SHIFT]});

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      acc_r <= '0;
    end else if (s3_v_r) begin
      acc_r <= neg3_r ? (acc_r - quot_x) : (acc_r + quot_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_load;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Saturate the sum to the sample range
  localparam logic signed [17:0] SUM_MAX = 18'sd32767;
  localparam logic signed [17:0] SUM_MIN = -18'sd32768;

  logic [SAMPLE_BITS-1:0] sat_sum;

  always_comb begin
    if (acc_r > SUM_MAX) begin
      sat_sum = 16'h7FFF;
    end else if (acc_r < SUM_MIN) begin
      sat_sum = 16'h8000;
    end else begin
      sat_sum = acc_r[SAMPLE_BITS-1:0];
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= sat_sum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A table write never shares a cycle with a table read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table write and read in the same cycle");

  // A sample transaction starts the read sequence
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_func == FUNC_SAMPLE)) |=> (state_r == S_RD_SQ))
    else $error("sample transaction did not start the read sequence");

  // Accumulation happens only while the pipeline drains
  a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (state_r == S_DRAIN_A || state_r == S_DRAIN_B ||
                state_r == S_DRAIN_C))
    else $error("term accumulated outside the drain window");

  // Phase moves only on a sample transaction
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !smp_acc |=> $stable(phase_r))
    else $error("phase changed without a sample transaction");
`endif

endmodule

// ----- tb/tb_wavetable_oscillator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_oscillator: self-checking bench for the wavetable oscillator
// Loads table entries just before a sample first reads them, runs a short
// directed sequence of extreme words and mixer levels, and then runs random
// load / refresh / sample traffic under several phase increments. Sender
// bursts and receiver stalls vary. Each sample on out_* is compared with a
// cycle-free predictor that is updated from every accepted input and
// configuration transaction.
// ----------------------------------------------------------------------------
module tb_wavetable_oscillator
  import wto_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int NUM_SETTINGS   = 9;
  localparam longint Q14        = 16384;

  typedef struct {
    func_t              func;
    tbl_t               sel;
    logic [9:0]         index;
    logic signed [15:0] word;
    logic [14:0]        shape;
  } osc_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic [3:0]  in_tuser = '0;
  logic [47:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [25:0] cfg_data = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  // Pending input transactions and predicted samples
  osc_item_t   pending_items[$];
  logic [15:0] expected_samples[$];

  // Generator view: phase at queue time and which entries hold a word
  logic [25:0] gen_phase = '0;
  logic [25:0] gen_increment = '0;
  bit          tbl_loaded [3][TABLE_SIZE];

  // Predictor state
  logic signed [15:0] square_tbl [TABLE_SIZE];
  logic signed [15:0] sine_tbl [TABLE_SIZE];
  logic signed [15:0] triangle_tbl [TABLE_SIZE];
  logic [25:0]        osc_phase = '0;
  logic [25:0]        osc_increment = '0;
  logic signed [15:0] held_square = '0;
  logic signed [15:0] held_sine = '0;
  logic signed [15:0] held_triangle = '0;
  int unsigned        mix_level = 0;

  bit in_fired = 1'b0;
  int errors = 0;
  int loads_seen = 0;
  int refreshes_seen = 0;
  int samples_checked = 0;
  int idle_cycles = 0;

  wavetable_oscillator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One table's contribution: weight * (0.3 cur + 0.7 prev), truncated to zero
  function automatic longint blend_term(longint weight, longint cur, longint prev);
    return (weight * (3 * cur + 7 * prev)) / (10 * Q14);
  endfunction

  // Queue one transaction; a sample first gets loads for any entry it reads
  // that holds no word yet
  task automatic queue_item(func_t func, tbl_t sel, int index, int word, int shape);
    osc_item_t itm;
    int        pos;
    if (func == FUNC_SAMPLE) begin
      pos = int'(gen_phase[25:16]);
      for (int t = 0; t < 3; t++)
        if (!tbl_loaded[t][pos])
          queue_item(FUNC_LOAD, tbl_t'(t), pos, $urandom, $urandom);
      gen_phase = gen_phase + gen_increment;
    end
    if (func == FUNC_LOAD && sel != TBL_NONE)
      tbl_loaded[sel][index[9:0]] = 1'b1;
    itm.func  = func;
    itm.sel   = sel;
    itm.index = index[9:0];
    itm.word  = word[15:0];
    itm.shape = shape[14:0];
    pending_items.push_back(itm);
  endtask

  task automatic write_increment(logic [25:0] inc_value);
    @(negedge clk);
    cfg_data  <= inc_value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued transaction is sent and every sample is back
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    osc_item_t itm;
    if (rst_n && (!in_tvalid || in_fired)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        itm = pending_items.pop_front();
        in_tuser  <= {itm.sel, itm.func};
        in_tdata  <= {7'd0, itm.shape, itm.word, itm.index};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: switch between always ready, a rotating pattern and random stalls
  int         stall_mode = 0;
  int         stall_hold = 0;
  logic [11:0] stall_pat = 12'b0000_1101_1011;

  always @(negedge clk) begin : receiver
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_hold = $urandom_range(20, 200);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: begin
        stall_pat = {stall_pat[10:0], stall_pat[11]};
        out_tready <= stall_pat[0];
      end
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Monitor: check samples, then advance the predictor on accepted transactions
  always @(posedge clk) begin : monitor
    func_t              func;
    tbl_t               sel;
    logic [9:0]         pos;
    logic [14:0]        shape;
    logic signed [15:0] word;
    logic signed [15:0] cur_sq, cur_si, cur_tr;
    logic [15:0]        want;
    longint             lvl, c, d, total;
    in_fired = in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample %0d with none expected", $time, $signed(out_tdata));
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: sample mismatch, expected %0d, actual %0d",
                     $time, $signed(want), $signed(out_tdata));
            errors++;
          end
          samples_checked++;
        end
      end

      if (cfg_valid && cfg_ready) osc_increment = cfg_data;

      if (in_fired) begin
        func  = func_t'(in_tuser[1:0]);
        sel   = tbl_t'(in_tuser[3:2]);
        pos   = in_tdata[9:0];
        word  = in_tdata[25:10];
        shape = in_tdata[40:26];
        case (func)
          FUNC_LOAD: begin
            loads_seen++;
            case (sel)
              TBL_SQUARE:   square_tbl[pos] = word;
              TBL_SINE:     sine_tbl[pos] = word;
              TBL_TRIANGLE: triangle_tbl[pos] = word;
              default: ;
            endcase
          end
          FUNC_REFRESH: begin
            refreshes_seen++;
            mix_level = (4 * mix_level + shape + 2) / 5;
          end
          FUNC_SAMPLE: begin
            lvl = mix_level;
            c = (lvl > Q14) ? Q14 : lvl;
            d = lvl - Q14;
            if (d < 0) d = 0;
            if (d > Q14) d = Q14;
            pos    = osc_phase[25:16];
            cur_sq = square_tbl[pos];
            cur_si = sine_tbl[pos];
            cur_tr = triangle_tbl[pos];
            total = blend_term(Q14 - c, cur_sq, held_square)
                  + blend_term(c - d, cur_si, held_sine)
                  + blend_term(d, cur_tr, held_triangle);
            if (total > 32767) total = 32767;
            if (total < -32768) total = -32768;
            expected_samples.push_back(total[15:0]);
            held_square   = cur_sq;
            held_sine     = cur_si;
            held_triangle = cur_tr;
            osc_phase     = osc_phase + osc_increment;
          end
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus: one increment setting per pass, idle between passes
  initial begin : stimulus
    logic [25:0] inc_value;
    int          roll;
    int          shape_mode;
    int          shape;
    tbl_t        sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: inc_value = 26'h3FF_0000;   // step back one entry per sample
        1: inc_value = 26'h000_0000;
        2: inc_value = 26'h3FF_FFFF;
        3: inc_value = 26'h000_0001;
        4: inc_value = 26'h001_0000;
        default: inc_value = ($urandom_range(0, 1) == 0) ?
                             26'($urandom_range(1, 26'h004_0000)) : 26'($urandom);
      endcase
      write_increment(inc_value);
      gen_increment = inc_value;

      if (p == 0) begin
        // Load a window of entries around entry 0 for the directed samples
        for (int t = 0; t < 3; t++)
          for (int i = -8; i < 8; i++)
            queue_item(FUNC_LOAD, tbl_t'(t), i & (TABLE_SIZE - 1), $urandom, $urandom);

        // Extreme words at both ends of the tables
        queue_item(FUNC_LOAD, TBL_SQUARE, 0, 32767, 0);
        queue_item(FUNC_LOAD, TBL_SINE, 0, -32768, 0);
        queue_item(FUNC_LOAD, TBL_TRIANGLE, 0, 32767, 0);
        queue_item(FUNC_LOAD, TBL_SQUARE, 1023, -32768, 0);
        queue_item(FUNC_LOAD, TBL_SINE, 1023, 32767, 0);
        queue_item(FUNC_LOAD, TBL_TRIANGLE, 1023, -32768, 0);
        // Pure square at zero mixer level
        queue_item(FUNC_SAMPLE, TBL_SQUARE, 0, 0, 0);
        queue_item(FUNC_SAMPLE, TBL_SQUARE, 0, 0, 0);
        // Unused table select and unused code must change nothing
        queue_item(FUNC_LOAD, TBL_NONE, 1022, 32767, 32767);
        queue_item(FUNC_NONE, TBL_NONE, 1023, -1, 32767);
        queue_item(FUNC_SAMPLE, TBL_SINE, 1023, -1, 32767);
        // Drive the mixer toward its top, then back down
        queue_item(FUNC_REFRESH, TBL_SQUARE, 0, 0, 32767);
        queue_item(FUNC_SAMPLE, TBL_SQUARE, 0, 0, 0);
        for (int k = 0; k < 5; k++)
          queue_item(FUNC_REFRESH, TBL_SQUARE, 0, 0, 32767);
        queue_item(FUNC_SAMPLE, TBL_SQUARE, 0, 0, 0);
        queue_item(FUNC_SAMPLE, TBL_SQUARE, 0, 0, 0);
        queue_item(FUNC_REFRESH, TBL_SQUARE, 0, 0, 0);
        queue_item(FUNC_REFRESH, TBL_SQUARE, 0, 0, 0);
        queue_item(FUNC_SAMPLE, TBL_SQUARE, 0, 0, 0);
      end else begin
        // Random traffic; shape targets lean high, low or spread per pass
        shape_mode = p % 3;
        for (int n = 0; n < 45; n++) begin
          case (shape_mode)
            0: shape = $urandom_range(0, 32767);
            1: shape = $urandom_range(30000, 32767);
            default: shape = $urandom_range(0, 2000);
          endcase
          sel  = tbl_t'($urandom_range(0, 2));
          roll = $urandom_range(0, 99);
          if (roll < 55)
            queue_item(FUNC_SAMPLE, tbl_t'($urandom_range(0, 3)), $urandom, $urandom, shape);
          else if (roll < 75)
            queue_item(FUNC_REFRESH, tbl_t'($urandom_range(0, 3)), $urandom, $urandom, shape);
          else if (roll < 90)
            queue_item(FUNC_LOAD, sel, $urandom, $urandom, shape);
          else if (roll < 95)
            queue_item(FUNC_LOAD, TBL_NONE, $urandom, $urandom, shape);
          else
            queue_item(FUNC_NONE, tbl_t'($urandom_range(0, 3)), $urandom, $urandom, shape);
        end
      end
      wait_drained();
    end

    $display("run covered %0d table loads, %0d mixer refreshes and %0d checked samples",
             loads_seen, refreshes_seen, samples_checked);
    $display("over %0d phase increment settings, %0d mismatches", NUM_SETTINGS, errors);
    if (errors == 0 && expected_samples.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
